@@ rtl/pcow_pkg.sv @@
package pcow_pkg;

  // Command characters.
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Field widths: the angle is held reduced mod 360, the strength saturated at 100.
  localparam int ANG_W = 9;
  localparam int STR_W = 7;

  localparam int DEG_FULL    = 360;
  localparam int DEG_QUARTER = 90;
  localparam int DEG_HALF    = 180;
  localparam int DEG_3Q      = 270;
  localparam int R3_DEG      = 60;
  localparam int STR_MAX     = 100;
  localparam int SPD_MAX     = 255;

  // floor(v/360) for v < 3600 is (v*2913) >> 20.
  localparam int ANG_RECIP    = 2913;
  localparam int ANG_RECIP_SH = 20;
  // floor(x/100) for x < 43699 is (x*5243) >> 19.
  localparam int SPD_RECIP    = 5243;
  localparam int SPD_RECIP_SH = 19;

  localparam int TRIG_FRAC_BITS_DEF = 15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VX,
    ST_VY,
    ST_R3,
    ST_W,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [ANG_W-1:0] angle;
    logic [STR_W-1:0] strength;
    logic             comma_seen;
  } parse_t;

  // Sine of k whole degrees (0..90) in Q30 by a nine-term integer Taylor series.
  function automatic logic [63:0] sin_q30(input int unsigned k);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] t;
    x   = (64'(k) * 64'd3373259426 + 64'd90) / 64'd180;
    sum = x;
    t   = x;
    for (int n = 1; n <= 8; n++) begin
      t = (((t * x) >> 30) * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) begin
        sum = sum - t;
      end else begin
        sum = sum + t;
      end
    end
    return sum;
  endfunction

  // Quarter-wave sine rounded from Q30 to Q(frac).
  function automatic logic [63:0] sin_qf_quarter(input int unsigned k, input int frac);
    logic [63:0] s;
    s = sin_q30(k);
    s = (s + (64'd1 << (29 - frac))) >> (30 - frac);
    return s;
  endfunction

  // t * 255 without a multiplier.
  function automatic logic [15:0] scale255(input logic [7:0] t);
    return {t, 8'h00} - {8'h00, t};
  endfunction

endpackage

@@ rtl/pcow_in_if.sv @@
interface pcow_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/pcow_out_if.sv @@
interface pcow_out_if;
  logic       valid;
  logic       ready;
  logic       dir_one;
  logic       dir_two;
  logic       dir_three;
  logic [7:0] speed_one;
  logic [7:0] speed_two;
  logic [7:0] speed_three;

  modport source (output valid, output dir_one, output dir_two, output dir_three,
                  output speed_one, output speed_two, output speed_three, input ready);
  modport sink   (input valid, input dir_one, input dir_two, input dir_three,
                  input speed_one, input speed_two, input speed_three, output ready);
endinterface

@@ rtl/pcow_sin_rom.sv @@
module pcow_sin_rom #(
  parameter int FRAC_BITS = pcow_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic [pcow_pkg::ANG_W-1:0] angle,
  output logic signed [FRAC_BITS+1:0] sine
);
  import pcow_pkg::*;

  localparam int TW = FRAC_BITS + 1;

  logic [TW-1:0]    tab [0:DEG_QUARTER];
  logic [6:0]       idx;
  logic [ANG_W-1:0] fold;
  logic             neg;
  logic [TW-1:0]    mag;

  for (genvar g = 0; g <= DEG_QUARTER; g++) begin : g_tab
    assign tab[g] = TW'(sin_qf_quarter(g, FRAC_BITS));
  end

  // Fold the angle into the first quadrant and remember the sign.
  always_comb begin
    if (angle < ANG_W'(DEG_QUARTER)) begin
      fold = angle;
      neg  = 1'b0;
    end else if (angle < ANG_W'(DEG_HALF)) begin
      fold = ANG_W'(DEG_HALF) - angle;
      neg  = 1'b0;
    end else if (angle < ANG_W'(DEG_3Q)) begin
      fold = angle - ANG_W'(DEG_HALF);
      neg  = 1'b1;
    end else begin
      fold = ANG_W'(DEG_FULL) - angle;
      neg  = 1'b1;
    end
    // For an angle below 360 the folded angle never exceeds 90, so seven bits index the table.
    idx  = 7'(fold);
    mag  = tab[idx];
    sine = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end
endmodule

@@ rtl/pcow_mul.sv @@
module pcow_mul #(
  parameter int WA = 23,
  parameter int WB = 17
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p_r
);
  // Shared signed multiplier with a registered product; the product holds while idle.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end
endmodule

@@ rtl/pcow_parser.sv @@
module pcow_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output pcow_pkg::parse_t st
);
  import pcow_pkg::*;

  logic [ANG_W-1:0] angle_r, angle_nxt;
  logic [STR_W-1:0] str_r, str_nxt;
  logic             comma_r, comma_nxt;
  logic             aend_r, aend_nxt;
  logic             send_r, send_nxt;

  logic             digit;
  logic [3:0]       dval;
  logic [11:0]      av;
  logic [23:0]      aq_full;
  logic [3:0]       aq;
  logic [11:0]      ar;
  logic [9:0]       sv;

  always_comb begin
    digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    dval    = 4'(rx_byte - CH_ZERO);
    av      = 12'(angle_r) * 12'd10 + 12'(dval);
    aq_full = 24'(av) * 24'(ANG_RECIP);
    aq      = aq_full[ANG_RECIP_SH +: 4];
    ar      = av - 12'(aq) * 12'(DEG_FULL);
    sv      = 10'(str_r) * 10'd10 + 10'(dval);

    angle_nxt = angle_r;
    str_nxt   = str_r;
    comma_nxt = comma_r;
    aend_nxt  = aend_r;
    send_nxt  = send_r;

    if (accept) begin
      if (rx_byte == CH_RPAREN) begin
        angle_nxt = '0;
        str_nxt   = '0;
        comma_nxt = 1'b0;
        aend_nxt  = 1'b0;
        send_nxt  = 1'b0;
      end else if (!comma_r) begin
        if (digit && !aend_r) begin
          angle_nxt = ar[ANG_W-1:0];
        end else if (rx_byte == CH_COMMA) begin
          comma_nxt = 1'b1;
          aend_nxt  = 1'b1;
        end else if (!digit) begin
          aend_nxt = 1'b1;
        end
      end else begin
        if (digit && !send_r) begin
          str_nxt = (sv > 10'(STR_MAX)) ? STR_W'(STR_MAX) : sv[STR_W-1:0];
        end else if (!digit) begin
          send_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      str_r   <= '0;
      comma_r <= 1'b0;
      aend_r  <= 1'b0;
      send_r  <= 1'b0;
    end else begin
      angle_r <= angle_nxt;
      str_r   <= str_nxt;
      comma_r <= comma_nxt;
      aend_r  <= aend_nxt;
      send_r  <= send_nxt;
    end
  end

  assign st.angle      = angle_r;
  assign st.strength   = str_r;
  assign st.comma_seen = comma_r;

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    angle_r < ANG_W'(DEG_FULL))
    else $error("angle accumulator left its mod-360 range");

  a_str_range: assert property (@(posedge clk) disable iff (!rst_n)
    str_r <= STR_W'(STR_MAX))
    else $error("strength accumulator above saturation limit");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && rx_byte == CH_RPAREN) |=> (!comma_r && angle_r == '0 && str_r == '0))
    else $error("parser state not cleared after terminator");
endmodule

@@ rtl/polar_command_omni_wheel_mixer_top.sv @@
// Each byte other than a terminating ')' is a plain transfer: in_ch.ready is high in idle.
// A ')' that follows a comma starts an eight-state sequence on one shared multiplier; the result
// is then presented on out_ch, and in_ch.ready returns at the same edge that loads the output
// register. The sequence waits in its last state while an untaken earlier result stalls out_ch.
// A ')' without a comma starts no sequence and leaves in_ch.ready high.
// Reset (rst_n low, synchronous) clears the parser, the sequencer and the output valid flag.
module polar_command_omni_wheel_mixer_top #(
  parameter int TRIG_FRAC_BITS = pcow_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pcow_in_if.sink   in_ch,
  pcow_out_if.source out_ch
);
  import pcow_pkg::*;

  // F is the fraction width of the sine table.  Vx and Vy are strength times a QF sine and
  // fit in F+8 signed bits; the wheel terms are Q2F and fit in 2F+9 signed bits.
  localparam int F  = TRIG_FRAC_BITS;
  localparam int SW = F + 2;
  localparam int WA = F + 8;
  localparam int WB = (F + 2 > 17) ? F + 2 : 17;
  localparam int WP = WA + WB;
  localparam int WW = 2 * F + 9;
  localparam int TW = 8;
  localparam int XW = 16;
  localparam int QW = 9;

  localparam logic signed [SW-1:0] R3_Q = SW'(sin_qf_quarter(R3_DEG, F));

  seq_state_t state_r, state_nxt;

  parse_t                 pst;
  logic                   in_fire;
  logic                   cmd_end;
  logic                   no_cmd;

  logic [ANG_W-1:0]       ang_r;
  logic [STR_W-1:0]       str_r;
  logic [ANG_W-1:0]       cos_angle;
  logic [ANG_W-1:0]       rom_angle;
  logic signed [SW-1:0]   rom_sine;

  logic                   mul_en;
  logic signed [WA-1:0]   mul_a;
  logic signed [WB-1:0]   mul_b;
  logic signed [WP-1:0]   mul_p;

  logic signed [WA-1:0]   vx_r;
  logic signed [WW-1:0]   vx_half;
  logic signed [WW-1:0]   r3vy;
  logic signed [WW-1:0]   w2;
  logic signed [WW-1:0]   w3;
  logic [WA-1:0]          vx_mag;
  logic [WW-1:0]          w2_mag;
  logic [WW-1:0]          w3_mag;
  logic [TW-1:0]          t1;
  logic [TW-1:0]          t2;
  logic [TW-1:0]          t3;

  logic [XW-1:0]          x1_r, x2_r, x3_r;
  logic [2:0]             dir_r;
  logic [QW-1:0]          quo;
  logic [TW-1:0]          spd;
  logic [TW-1:0]          sp1_r, sp2_r;
  logic                   out_load;

  logic                   out_valid_r;
  logic                   dir1_o_r, dir2_o_r, dir3_o_r;
  logic [TW-1:0]          spd1_o_r, spd2_o_r, spd3_o_r;

  // ---------------------------------------------------------------------------------------
  // Input side: the parser takes every transfer; only a ')' after a comma starts the maths.
  // ---------------------------------------------------------------------------------------
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cmd_end     = in_fire && (in_ch.rx_byte == CH_RPAREN) && pst.comma_seen;
  assign no_cmd      = in_fire && (in_ch.rx_byte == CH_RPAREN) && !pst.comma_seen;

  pcow_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .rx_byte (in_ch.rx_byte),
    .st      (pst)
  );

  // The single sine table is shared: the cosine is read as the sine of the angle plus 90.
  assign cos_angle = (ang_r >= ANG_W'(DEG_3Q)) ? ang_r - ANG_W'(DEG_3Q)
                                               : ang_r + ANG_W'(DEG_QUARTER);

  pcow_sin_rom #(.FRAC_BITS(F)) u_sin (
    .angle (rom_angle),
    .sine  (rom_sine)
  );

  pcow_mul #(.WA(WA), .WB(WB)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // ---------------------------------------------------------------------------------------
  // Sequencer.  The multiplier product is registered, so a step that uses a product takes it from
  // the step before it:
  //   VX: S*cos      VY: S*sin (Vx lands)     R3: Vy*sqrt3/2 (Vy lands)
  //   W : wheel sums, magnitudes and directions
  //   D1..D3: each t*255 times the reciprocal of 100, one wheel per step
  //   DONE: the last quotient lands and the result waits for the output register.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    rom_angle = ang_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_end) begin
          state_nxt = ST_VX;
        end
      end
      ST_VX: begin
        mul_en    = 1'b1;
        rom_angle = cos_angle;
        mul_a     = $signed(WA'(str_r));
        mul_b     = WB'(rom_sine);
        state_nxt = ST_VY;
      end
      ST_VY: begin
        mul_en    = 1'b1;
        mul_a     = $signed(WA'(str_r));
        mul_b     = WB'(rom_sine);
        state_nxt = ST_R3;
      end
      ST_R3: begin
        mul_en    = 1'b1;
        mul_a     = $signed(mul_p[WA-1:0]);
        mul_b     = WB'(R3_Q);
        state_nxt = ST_W;
      end
      ST_W: begin
        state_nxt = ST_D1;
      end
      ST_D1: begin
        mul_en    = 1'b1;
        mul_a     = $signed(WA'(SPD_RECIP));
        mul_b     = $signed(WB'(x1_r));
        state_nxt = ST_D2;
      end
      ST_D2: begin
        mul_en    = 1'b1;
        mul_a     = $signed(WA'(SPD_RECIP));
        mul_b     = $signed(WB'(x2_r));
        state_nxt = ST_D3;
      end
      ST_D3: begin
        mul_en    = 1'b1;
        mul_a     = $signed(WA'(SPD_RECIP));
        mul_b     = $signed(WB'(x3_r));
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Wheel mixing.  w1 = -Vx*2^F, so its truncated magnitude is simply |Vx| >> F.
  // w2 and w3 are Vx*2^(F-1) minus and plus sqrt3/2*Vy, truncated by 2F bits.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    vx_half = WW'(vx_r) <<< (F - 1);
    r3vy    = $signed(mul_p[WW-1:0]);
    w2      = vx_half - r3vy;
    w3      = vx_half + r3vy;
    vx_mag  = vx_r[WA-1] ? WA'(-vx_r) : WA'(vx_r);
    w2_mag  = w2[WW-1] ? WW'(-w2) : WW'(w2);
    w3_mag  = w3[WW-1] ? WW'(-w3) : WW'(w3);
    t1      = TW'(vx_mag >> F);
    t2      = TW'(w2_mag >> (2 * F));
    t3      = TW'(w3_mag >> (2 * F));
  end

  // Speed is floor(t*255/100), clipped at full duty.
  assign quo = mul_p[SPD_RECIP_SH +: QW];
  assign spd = (quo > QW'(SPD_MAX)) ? TW'(SPD_MAX) : quo[TW-1:0];

  always_ff @(posedge clk) begin
    if (cmd_end) begin
      ang_r <= pst.angle;
      str_r <= pst.strength;
    end
    if (state_r == ST_VY) begin
      vx_r <= $signed(mul_p[WA-1:0]);
    end
    if (state_r == ST_W) begin
      x1_r  <= scale255(t1);
      x2_r  <= scale255(t2);
      x3_r  <= scale255(t3);
      // Direction is 0 for a negative wheel velocity; w1 is negative when Vx is positive.
      dir_r <= {~w3[WW-1], ~w2[WW-1], ~(!vx_r[WA-1] && (vx_r != '0))};
    end
    if (state_r == ST_D2) begin
      sp1_r <= spd;
    end
    if (state_r == ST_D3) begin
      sp2_r <= spd;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register: the finished result waits here until the sink takes the transfer.
  // ---------------------------------------------------------------------------------------
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dir1_o_r <= dir_r[0];
      dir2_o_r <= dir_r[1];
      dir3_o_r <= dir_r[2];
      spd1_o_r <= sp1_r;
      spd2_o_r <= sp2_r;
      spd3_o_r <= spd;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.dir_one     = dir1_o_r;
  assign out_ch.dir_two     = dir2_o_r;
  assign out_ch.dir_three   = dir3_o_r;
  assign out_ch.speed_one   = spd1_o_r;
  assign out_ch.speed_two   = spd2_o_r;
  assign out_ch.speed_three = spd3_o_r;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_end |=> (state_r == ST_VX))
    else $error("terminator after a comma did not start the sequence");

  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    no_cmd |=> (state_r == ST_IDLE && !$rose(out_valid_r)))
    else $error("terminator without a comma started work");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result presented without a finished sequence");

  a_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ch.ready) |=> (state_r == ST_DONE))
    else $error("finished result dropped while the output was stalled");
endmodule
